@@ rtl/core/ufc_pkg.sv @@
// ----------------------------------------------------------------------------
// ufc_pkg
// Shared constants, status codes and control types of the connectivity core.
// ----------------------------------------------------------------------------
package ufc_pkg;

	localparam int MAX_VERTICES_DEFAULT = 65535;
	localparam int VCOUNT_RESET         = 65535;
	localparam int RANK_W               = 5;
	localparam int RANK_MAX             = 31;

	typedef enum logic [1:0] {
		STATUS_MERGED  = 2'd0,
		STATUS_SAME    = 2'd1,
		STATUS_IGNORED = 2'd2,
		STATUS_CLEARED = 2'd3
	} status_t;

	// Handshake between the top level and the find/merge sequencer.
	typedef struct packed {
		logic idle;
		logic done;
		logic merged;
	} seq_status_t;

endpackage

@@ rtl/core/ufc_edge_if.sv @@
// ----------------------------------------------------------------------------
// ufc_edge_if
// Input channel: one edge or clear command per beat.
// ----------------------------------------------------------------------------
interface ufc_edge_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] first_vertex;
	logic [15:0] second_vertex;

	modport source (output valid, func, first_vertex, second_vertex, input ready);
	modport sink   (input valid, func, first_vertex, second_vertex, output ready);
endinterface

@@ rtl/core/ufc_result_if.sv @@
// ----------------------------------------------------------------------------
// ufc_result_if
// Result channel: one status and totals report per beat.
// ----------------------------------------------------------------------------
interface ufc_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] merged_root;
	logic [15:0] component_count;
	logic [15:0] largest_size;
	logic [31:0] edges_processed;

	modport source (output valid, status, merged_root, component_count, largest_size,
		edges_processed, input ready);
	modport sink   (input valid, status, merged_root, component_count, largest_size,
		edges_processed, output ready);
endinterface

@@ rtl/core/ufc_ram.sv @@
// ----------------------------------------------------------------------------
// ufc_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ufc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/ufc_seq.sv @@
// ----------------------------------------------------------------------------
// ufc_seq
// Find/merge sequencer: two path-halving root walks, then union by rank if the roots differ.
// ----------------------------------------------------------------------------
module ufc_seq #(
	parameter int VW = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VW-1:0]          vert_a,
	input  logic [VW-1:0]          vert_b,
	input  logic                   ack,
	output ufc_pkg::seq_status_t   stat,
	output logic [VW-1:0]          root,
	output logic [VW-1:0]          new_size,
	output logic [VW-1:0]          raddr,
	input  logic [2*VW+ufc_pkg::RANK_W-1:0] rdata,
	output logic                   we,
	output logic [VW-1:0]          waddr,
	output logic [2*VW+ufc_pkg::RANK_W-1:0] wdata
);
	import ufc_pkg::*;

	localparam int SIZE_LO = VW;
	localparam int RANK_LO = 2 * VW;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RDV  = 7'b0000010,
		S_WV   = 7'b0000100,
		S_WP   = 7'b0001000,
		S_MRG1 = 7'b0010000,
		S_MRG2 = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t              state_q;
	logic                phase_q;
	logic                merged_q;
	logic [VW-1:0]       v_q, b_q;
	logic [VW-1:0]       wv_par_q, wv_size_q;
	logic [RANK_W-1:0]   wv_rank_q;
	logic [VW-1:0]       ra_q, ra_size_q;
	logic [RANK_W-1:0]   ra_rank_q;
	logic [VW-1:0]       win_q, lose_q, lose_size_q, sum_q;
	logic [RANK_W-1:0]   win_rank_q, lose_rank_q;

	logic [VW-1:0]       rd_par, rd_size;
	logic [RANK_W-1:0]   rd_rank;
	logic                found, rd_issue;
	logic [VW-1:0]       froot;
	logic [RANK_W-1:0]   rank_bump;

	assign rd_par  = rdata[VW-1:0];
	assign rd_size = rdata[SIZE_LO +: VW];
	assign rd_rank = rdata[RANK_LO +: RANK_W];

	assign rank_bump = (win_rank_q == lose_rank_q && win_rank_q < RANK_W'(RANK_MAX))
		? RANK_W'(1) : RANK_W'(0);

	always_comb begin
		raddr    = v_q;
		rd_issue = 1'b0;
		we       = 1'b0;
		waddr    = v_q;
		wdata    = '0;
		found    = 1'b0;
		froot    = v_q;
		unique case (state_q)
			S_RDV: begin
				rd_issue = 1'b1;
			end
			S_WV: begin
				if (rd_par == v_q) begin
					found = 1'b1;
				end else begin
					raddr    = rd_par;
					rd_issue = 1'b1;
				end
			end
			S_WP: begin
				// Halve the path: the visited vertex skips to its grandparent.
				we    = 1'b1;
				wdata = {wv_rank_q, wv_size_q, rd_par};
				if (rd_par == wv_par_q) begin
					found = 1'b1;
					froot = rd_par;
				end
			end
			S_MRG1: begin
				we    = 1'b1;
				waddr = lose_q;
				wdata = {lose_rank_q, lose_size_q, win_q};
			end
			S_MRG2: begin
				we    = 1'b1;
				waddr = win_q;
				wdata = {win_rank_q + rank_bump, sum_q, win_q};
			end
			S_IDLE, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			phase_q  <= 1'b0;
			merged_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						phase_q <= 1'b0;
						state_q <= S_RDV;
					end
				end
				S_RDV: state_q <= S_WV;
				S_WV: begin
					if (!found) begin
						state_q <= S_WP;
					end
				end
				S_WP: begin
					if (!found) begin
						state_q <= S_RDV;
					end
				end
				S_MRG1: state_q <= S_MRG2;
				S_MRG2: state_q <= S_DONE;
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (found) begin
				if (!phase_q) begin
					phase_q <= 1'b1;
					state_q <= S_RDV;
				end else if (froot == ra_q) begin
					merged_q <= 1'b0;
					state_q  <= S_DONE;
				end else begin
					merged_q <= 1'b1;
					state_q  <= S_MRG1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			v_q <= vert_a;
			b_q <= vert_b;
		end
		if (state_q == S_WV) begin
			wv_par_q  <= rd_par;
			wv_size_q <= rd_size;
			wv_rank_q <= rd_rank;
		end
		if (state_q == S_WP) begin
			v_q <= rd_par;
		end
		if (found) begin
			if (!phase_q) begin
				ra_q      <= froot;
				ra_size_q <= rd_size;
				ra_rank_q <= rd_rank;
				v_q       <= b_q;
			end else begin
				// Ties go to the root of the first vertex.
				sum_q <= ra_size_q + rd_size;
				if (ra_rank_q < rd_rank) begin
					win_q       <= froot;
					win_rank_q  <= rd_rank;
					lose_q      <= ra_q;
					lose_rank_q <= ra_rank_q;
					lose_size_q <= ra_size_q;
				end else begin
					win_q       <= ra_q;
					win_rank_q  <= ra_rank_q;
					lose_q      <= froot;
					lose_rank_q <= rd_rank;
					lose_size_q <= rd_size;
				end
			end
		end
	end

	assign stat.idle   = (state_q == S_IDLE);
	assign stat.done   = (state_q == S_DONE);
	assign stat.merged = merged_q;
	assign root        = win_q;
	assign new_size    = sum_q;

`ifndef NO_ASSERTIONS
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(we && rd_issue) |-> (waddr != raddr))
		else $error("read issued to the entry being written");
	a_merge_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.done && stat.merged) |-> (win_q != lose_q))
		else $error("merge of a root with itself");
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		stat.idle |-> !we)
		else $error("node memory written while the sequencer is idle");
`endif
endmodule

@@ rtl/core/union_find_connectivity_core.sv @@
// ----------------------------------------------------------------------------
// union_find_connectivity_core
// Disjoint-set engine with path halving and union by rank, one result per beat.
// ----------------------------------------------------------------------------
// Each input beat is an edge or a clear command, and each produces exactly one
// result beat with the running component count, largest set size and edge
// count. Ignored edges and clears answer at once from the output register.
// A valid edge runs two root walks through the node memory: each step reads
// a vertex and waits for its entry; a vertex that is not a root then has its
// parent read and is halved with a write of its grandparent. A merge adds two
// writes, loser then winner, before the result is handed over, and a new edge
// is taken only once the sequencer is back in idle, so edges do not overlap.
// The single read port of the node memory sets the pace of the walks. After
// reset, after a clear beat and after every write of the vertex count the
// memory is swept, one entry per cycle, over all MAX_VERTICES+1 entries
// (65536 at the default); the input stays stalled during the sweep, while
// configuration writes are taken as always.
// ----------------------------------------------------------------------------
module union_find_connectivity_core #(
	parameter int MAX_VERTICES = ufc_pkg::MAX_VERTICES_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [15:0]         wr_data,
	ufc_edge_if.sink            req,
	ufc_result_if.source        rsp
);
	import ufc_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES + 1);
	localparam int MW = 2 * VW + RANK_W;
	localparam logic [15:0] VCOUNT_RST =
		16'((MAX_VERTICES < VCOUNT_RESET) ? MAX_VERTICES : VCOUNT_RESET);

	// Totals and configuration.
	logic [15:0]   vcount_q;
	logic [15:0]   comp_q;
	logic [VW-1:0] largest_q;
	logic [31:0]   tally_q;

	// Clearing sweep over the node memory.
	logic          sweep_q;
	logic [VW-1:0] sweep_idx_q;

	// Output register.
	logic          rsp_valid_q;
	status_t       rsp_status_q;
	logic [15:0]   rsp_root_q;
	logic [15:0]   rsp_comp_q;
	logic [15:0]   rsp_large_q;
	logic [31:0]   rsp_tally_q;

	seq_status_t   seq_stat;
	logic [VW-1:0] seq_root, seq_size, seq_raddr, seq_waddr;
	logic          seq_we, seq_ack, seq_start;
	logic [MW-1:0] seq_wdata, ram_rdata, ram_wdata;
	logic          ram_we;
	logic [VW-1:0] ram_waddr;

	logic          accept, slot_free, is_clear, is_ignored, clear_evt;
	logic [15:0]   cfg_val;
	logic [15:0]   comp_next;
	logic [VW-1:0] large_next;

	// The output slot frees up in the same cycle that its beat is taken.
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = !sweep_q && seq_stat.idle && slot_free;
	assign accept    = req.valid && req.ready;

	assign is_clear   = req.func;
	assign is_ignored = (req.second_vertex == 16'd0) || (req.second_vertex > vcount_q)
		|| (req.first_vertex == 16'd0) || (req.first_vertex >= req.second_vertex);

	assign seq_start = accept && !is_clear && !is_ignored;
	assign seq_ack   = seq_stat.done && slot_free;
	assign clear_evt = wr_en || (accept && is_clear);

	always_comb begin
		cfg_val = (wr_data == 16'd0) ? 16'd1 : wr_data;
		if (32'(cfg_val) > 32'(MAX_VERTICES)) begin
			cfg_val = 16'(MAX_VERTICES);
		end
	end

	// Totals after a finished edge walk.
	always_comb begin
		comp_next  = comp_q;
		large_next = largest_q;
		if (seq_stat.merged) begin
			if (comp_q != 16'd0) begin
				comp_next = comp_q - 16'd1;
			end
			if (seq_size > largest_q) begin
				large_next = seq_size;
			end
		end
	end

	// The sweep owns the write port; the sequencer starts no new edge during it.
	assign ram_we    = sweep_q || seq_we;
	assign ram_waddr = sweep_q ? sweep_idx_q : seq_waddr;
	assign ram_wdata = sweep_q ? {RANK_W'(0), VW'(1), sweep_idx_q} : seq_wdata;

	ufc_ram #(
		.WIDTH (MW),
		.DEPTH (MAX_VERTICES + 1)
	) u_nodes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (seq_raddr),
		.rdata (ram_rdata)
	);

	ufc_seq #(
		.VW (VW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (seq_start),
		.vert_a   (VW'(req.first_vertex)),
		.vert_b   (VW'(req.second_vertex)),
		.ack      (seq_ack),
		.stat     (seq_stat),
		.root     (seq_root),
		.new_size (seq_size),
		.raddr    (seq_raddr),
		.rdata    (ram_rdata),
		.we       (seq_we),
		.waddr    (seq_waddr),
		.wdata    (seq_wdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= VCOUNT_RST;
			comp_q      <= 16'(VCOUNT_RESET);
			largest_q   <= VW'(1);
			tally_q     <= 32'd0;
			sweep_q     <= 1'b1;
			sweep_idx_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (sweep_q) begin
				if (sweep_idx_q == VW'(MAX_VERTICES)) begin
					sweep_q <= 1'b0;
				end else begin
					sweep_idx_q <= sweep_idx_q + VW'(1);
				end
			end
			if (seq_start && tally_q != 32'hFFFF_FFFF) begin
				tally_q <= tally_q + 32'd1;
			end
			if (seq_ack) begin
				comp_q      <= comp_next;
				largest_q   <= large_next;
				rsp_valid_q <= 1'b1;
			end
			if (accept && (is_clear || is_ignored)) begin
				rsp_valid_q <= 1'b1;
			end
			if (accept && is_clear) begin
				comp_q      <= vcount_q;
				largest_q   <= VW'(1);
				tally_q     <= 32'd0;
				sweep_q     <= 1'b1;
				sweep_idx_q <= '0;
			end
			// A vertex count write restarts from singletons as well.
			if (wr_en) begin
				vcount_q    <= cfg_val;
				comp_q      <= cfg_val;
				largest_q   <= VW'(1);
				tally_q     <= 32'd0;
				sweep_q     <= 1'b1;
				sweep_idx_q <= '0;
			end
		end
	end

	// Result payload, loaded alongside the valid flag.
	always_ff @(posedge clk) begin
		if (seq_ack) begin
			rsp_status_q <= seq_stat.merged ? STATUS_MERGED : STATUS_SAME;
			rsp_root_q   <= seq_stat.merged ? 16'(seq_root) : 16'd0;
			rsp_comp_q   <= comp_next;
			rsp_large_q  <= 16'(large_next);
			rsp_tally_q  <= tally_q;
		end else if (accept && is_clear) begin
			rsp_status_q <= STATUS_CLEARED;
			rsp_root_q   <= 16'd0;
			rsp_comp_q   <= vcount_q;
			rsp_large_q  <= 16'd1;
			rsp_tally_q  <= 32'd0;
		end else if (accept && is_ignored) begin
			rsp_status_q <= STATUS_IGNORED;
			rsp_root_q   <= 16'd0;
			rsp_comp_q   <= comp_q;
			rsp_large_q  <= 16'(largest_q);
			rsp_tally_q  <= tally_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.merged_root     = rsp_root_q;
	assign rsp.component_count = rsp_comp_q;
	assign rsp.largest_size    = rsp_large_q;
	assign rsp.edges_processed = rsp_tally_q;

`ifndef NO_ASSERTIONS
	a_clear_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		clear_evt |=> sweep_q)
		else $error("clear did not start a memory sweep");
	a_tally_grows: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_evt |=> (tally_q >= $past(tally_q)))
		else $error("edge count went down without a clear");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp_status_q)
		&& $stable(rsp_root_q) && $stable(rsp_comp_q) && $stable(rsp_tally_q)))
		else $error("result beat changed while waiting");
`endif
endmodule

@@ dv/ufc_scoreboard.sv @@
// ----------------------------------------------------------------------------
// ufc_scoreboard
// Watches the edge and result channels of the connectivity core, keeps its
// own disjoint-set model and compares every result beat field by field.
// ----------------------------------------------------------------------------
module ufc_scoreboard #(
	parameter int MAX_VERTICES = ufc_pkg::MAX_VERTICES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [15:0] wr_data,
	input  logic        end_check,
	ufc_edge_if         edge_mon,
	ufc_result_if       result_mon,
	output int          fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import ufc_pkg::*;

	typedef struct {
		status_t     status;
		logic [15:0] merged_root;
		logic [15:0] component_count;
		logic [15:0] largest_size;
		logic [31:0] edges_processed;
	} report_t;

	int unsigned link_of [0:65535];
	int unsigned size_of [0:65535];
	int unsigned rank_of [0:65535];
	int unsigned vcount;
	int unsigned components;
	int unsigned largest;
	int unsigned edge_total;
	report_t     pending_reports[$];
	bit          leftovers_checked;

	function automatic void make_singletons();
		for (int i = 0; i <= 65535; i++) begin
			link_of[i] = i;
			size_of[i] = 1;
			rank_of[i] = 0;
		end
		components = vcount;
		largest = 1;
		edge_total = 0;
	endfunction

	// Root walk with path halving: every visited node skips to its grandparent.
	function automatic int unsigned walk_to_root(int unsigned v);
		while (link_of[v] != v) begin
			link_of[v] = link_of[link_of[v]];
			v = link_of[v];
		end
		return v;
	endfunction

	function automatic report_t apply_item(bit func, int unsigned a, int unsigned b);
		report_t     r;
		int unsigned ra;
		int unsigned rb;
		int unsigned t;
		r.status = STATUS_IGNORED;
		r.merged_root = '0;
		if (func) begin
			make_singletons();
			r.status = STATUS_CLEARED;
		end else if (!(b < 1 || b > vcount || a == 0 || a >= b)) begin
			if (edge_total != 32'hFFFF_FFFF)
				edge_total++;
			ra = walk_to_root(a);
			rb = walk_to_root(b);
			if (ra == rb) begin
				r.status = STATUS_SAME;
			end else begin
				if (rank_of[ra] < rank_of[rb]) begin
					t = ra;
					ra = rb;
					rb = t;
				end
				link_of[rb] = ra;
				size_of[ra] += size_of[rb];
				if (rank_of[ra] == rank_of[rb] && rank_of[ra] < RANK_MAX)
					rank_of[ra]++;
				if (components > 0)
					components--;
				if (size_of[ra] > largest)
					largest = size_of[ra];
				r.status = STATUS_MERGED;
				r.merged_root = ra[15:0];
			end
		end
		r.component_count = components[15:0];
		r.largest_size = largest[15:0];
		r.edges_processed = edge_total;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		report_t     want;
		int unsigned v;
		int          errs;
		errs = 0;
		if (!arst_n) begin
			vcount = (VCOUNT_RESET > MAX_VERTICES) ? MAX_VERTICES : VCOUNT_RESET;
			make_singletons();
			components = VCOUNT_RESET;
			pending_reports.delete();
			fail_count <= 0;
			leftovers_checked = 0;
		end else begin
			if (wr_en) begin
				v = 32'(wr_data);
				if (v < 1)
					v = 1;
				if (v > MAX_VERTICES)
					v = MAX_VERTICES;
				vcount = v;
				make_singletons();
			end
			if (edge_mon.valid && edge_mon.ready) begin
				want = apply_item(edge_mon.func, 32'(edge_mon.first_vertex),
					32'(edge_mon.second_vertex));
				pending_reports = {pending_reports, want};
			end
			if (result_mon.valid && result_mon.ready) begin
				if (pending_reports.size() == 0) begin
					$error("result beat with no expectation pending");
					errs++;
				end else begin
					want = pending_reports.pop_front();
					if (result_mon.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result_mon.status);
						errs++;
					end
					if (result_mon.merged_root !== want.merged_root) begin
						$error("merged_root: expected %0d, got %0d", want.merged_root,
							result_mon.merged_root);
						errs++;
					end
					if (result_mon.component_count !== want.component_count) begin
						$error("component_count: expected %0d, got %0d",
							want.component_count, result_mon.component_count);
						errs++;
					end
					if (result_mon.largest_size !== want.largest_size) begin
						$error("largest_size: expected %0d, got %0d", want.largest_size,
							result_mon.largest_size);
						errs++;
					end
					if (result_mon.edges_processed !== want.edges_processed) begin
						$error("edges_processed: expected %0d, got %0d",
							want.edges_processed, result_mon.edges_processed);
						errs++;
					end
				end
			end
			if (end_check && !leftovers_checked) begin
				leftovers_checked = 1;
				if (pending_reports.size() != 0) begin
					$error("%0d expected results never arrived", pending_reports.size());
					errs++;
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end
endmodule

@@ dv/tb_union_find_connectivity_core.sv @@
// ----------------------------------------------------------------------------
// tb_union_find_connectivity_core
// Stimulus and verdict for the connectivity core: directed edges, clears and
// vertex count writes, then random edge traffic at several vertex counts with
// random idling on both channels. Checking lives in ufc_scoreboard.
// ----------------------------------------------------------------------------
module tb_union_find_connectivity_core;
	timeunit 1ns;
	timeprecision 1ps;

	// Each reset, clear beat and vertex count write starts a full memory sweep.
	// The run has about ten of those, so the cycle budget is dominated by them;
	// the limit leaves ample room above that.
	localparam int CYCLE_LIMIT = 4_000_000;
	// Slack after the last result, well above a long find walk.
	localparam int TAIL_CYCLES = 64;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [15:0] wr_data;
	logic        end_check;
	int          fail_count;
	int          beats_sent;
	int          beats_back;
	int          cycle_count;
	bit          quiet;        // when set, neither side inserts gaps
	bit          hold_results; // request for one long receiver hold-off

	ufc_edge_if   req_if();
	ufc_result_if rsp_if();

	union_find_connectivity_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_data(wr_data),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	ufc_scoreboard checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_data   (wr_data),
		.end_check (end_check),
		.edge_mon  (req_if),
		.result_mon(rsp_if),
		.fail_count(fail_count)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Result side: random back-pressure, plus one long hold-off on request so
	// that the core fills up and stalls its input.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else if (hold_results) begin
				hold_results = 0;
				stall_left = 400;
				rsp_if.ready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				rsp_if.ready <= (stall_left == 0);
			end
		end
	end

	always @(posedge clk)
		if (rsp_if.valid && rsp_if.ready)
			beats_back <= beats_back + 1;

	// Offers one beat and returns at the edge that accepts it. Valid is left
	// high so that back-to-back beats need no second assignment in one step.
	task automatic send_beat(bit func, logic [15:0] a, logic [15:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.func <= func;
		req_if.first_vertex <= a;
		req_if.second_vertex <= b;
		do
			@(posedge clk);
		while (!req_if.ready);
		beats_sent++;
	endtask

	// Stops offering beats and waits until every result is back.
	task automatic wait_all_back();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (beats_back != beats_sent)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// The vertex count is only written with the core idle. The write also
	// clears every set, which starts a full memory sweep inside the core.
	task automatic write_vertex_count(logic [15:0] value);
		wait_all_back();
		wr_en <= 1'b1;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		wr_data <= 16'($urandom);
	endtask

	// Mostly in-range edges at vertex counts from two, with random endpoints so
	// that sets grow, join and get long paths; the rest is unfiltered noise.
	task automatic random_edges(int unsigned vcount, int count, bit with_hold);
		logic [15:0] a;
		logic [15:0] b;
		for (int i = 0; i < count; i++) begin
			quiet = ((i / 40) % 3 == 2);
			if (with_hold && i == count / 2)
				hold_results = 1;
			if (vcount >= 2 && $urandom_range(0, 99) < 85) begin
				b = 16'($urandom_range(2, vcount));
				a = 16'($urandom_range(1, 32'(b) - 1));
			end else begin
				a = 16'($urandom);
				b = 16'($urandom);
			end
			send_beat(1'b0, a, b);
		end
		quiet = 0;
	endtask

	initial begin
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_data <= '0;
		end_check <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.func <= 1'b0;
		req_if.first_vertex <= '0;
		req_if.second_vertex <= '0;
		beats_sent = 0;
		beats_back = 0;
		cycle_count = 0;
		quiet = 0;
		hold_results = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset vertex count of 65535.
		send_beat(1'b0, 16'd1, 16'd2);          // plain merge
		send_beat(1'b0, 16'd2, 16'd3);          // joins a singleton into a set
		send_beat(1'b0, 16'd1, 16'd3);          // both ends already in one set
		send_beat(1'b0, 16'd0, 16'd5);          // first vertex zero
		send_beat(1'b0, 16'd5, 16'd0);          // second vertex zero
		send_beat(1'b0, 16'd5, 16'd5);          // first not below second
		send_beat(1'b0, 16'd7, 16'd5);
		send_beat(1'b0, 16'd1, 16'd65535);      // highest vertex id
		send_beat(1'b0, 16'd65534, 16'd65535);
		send_beat(1'b0, 16'hFFFF, 16'hFFFF);
		send_beat(1'b0, 16'd10, 16'd11);        // two rank-one sets ...
		send_beat(1'b0, 16'd12, 16'd13);
		send_beat(1'b0, 16'd10, 16'd12);        // ... tie: first root wins
		send_beat(1'b0, 16'd9, 16'd10);         // lower rank first: roots swap
		send_beat(1'b1, 16'hFFFF, 16'hFFFF);    // clear with all field bits set
		send_beat(1'b0, 16'd1, 16'd2);
		wait_all_back();

		// Vertex count zero saturates to one: no edge can pass.
		write_vertex_count(16'd0);
		send_beat(1'b0, 16'd1, 16'd1);
		send_beat(1'b0, 16'd1, 16'd2);
		send_beat(1'b0, 16'd0, 16'd1);
		random_edges(1, 60, 0);

		write_vertex_count(16'd2);
		send_beat(1'b0, 16'd1, 16'd2);
		send_beat(1'b0, 16'd1, 16'd2);
		send_beat(1'b0, 16'd1, 16'd3);          // second vertex above the count
		send_beat(1'b1, 16'd0, 16'd0);          // clear with all field bits low
		random_edges(2, 40, 0);

		write_vertex_count(16'd8);
		random_edges(8, 120, 0);

		// Mid-sized sets give long paths; the receiver holds off once here.
		write_vertex_count(16'd40);
		random_edges(40, 200, 1);

		// The sender pauses until the pipeline has drained, then resumes.
		wait_all_back();
		random_edges(40, 60, 0);

		write_vertex_count(16'd300);
		random_edges(300, 200, 0);

		write_vertex_count(16'd65535);
		random_edges(65535, 100, 0);

		wait_all_back();
		end_check <= 1'b1;
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
